[design/ir_dm_pkg.sv]
// ----------------------------------------------------------------------------
// ir_dm_pkg
// Shared constants and types for the IR array direction and median block.
// ----------------------------------------------------------------------------
package ir_dm_pkg;

   // array and window size
   localparam int SENSOR_COUNT  = 9;
   localparam int WINDOW_DEPTH  = 10;
   localparam int FRACTION_BITS = 8;

   // port widths fixed by the interface
   localparam int SENSOR_W = 9;
   localparam int DIR_W    = 12;
   localparam int MED_W    = 13;

   // derived widths
   localparam int CNT_W      = $clog2(SENSOR_COUNT + 1);
   localparam int SUM_MAX    = SENSOR_COUNT * (SENSOR_COUNT - 1) / 2;
   localparam int SUM_W      = (SUM_MAX > 1) ? $clog2(SUM_MAX + 1) : 1;
   localparam int DIVIDEND_W = SUM_W + FRACTION_BITS;
   localparam int STEP_W     = $clog2(DIVIDEND_W);
   localparam int IDX_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int RANK_W     = $clog2(WINDOW_DEPTH + 1);

   // classified snapshot passed from front to back
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sum;
   } task_type;

   // queue status seen by the back end
   typedef struct packed {
      logic     valid;
      task_type item;
   } queue_out_type;

endpackage

[design/ir_dm_front.sv]
// ----------------------------------------------------------------------------
// ir_dm_front
// Classifies one receiver snapshot into active count and index sum.
// ----------------------------------------------------------------------------
module ir_dm_front (
   input  logic [ir_dm_pkg::SENSOR_W-1:0] sensor_bits,
   output ir_dm_pkg::task_type            item
);
   import ir_dm_pkg::*;

   logic [CNT_W-1:0] count;
   logic [SUM_W-1:0] sum;

   // count active receivers and add up their indexes
   always_comb begin
      count = '0;
      sum   = '0;
      for (int i = 0; i < SENSOR_W; i++) begin
         if (i < SENSOR_COUNT && sensor_bits[i]) begin
            count = count + CNT_W'(1);
            sum   = sum + SUM_W'(i);
         end
      end
   end

   assign item.count = count;
   assign item.sum   = sum;

endmodule

[design/ir_dm_queue.sv]
// ----------------------------------------------------------------------------
// ir_dm_queue
// Two-entry queue that decouples request intake from the back end.
// ----------------------------------------------------------------------------
module ir_dm_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ir_dm_pkg::task_type       push_item,
   output logic                      full,
   input  logic                      pop,
   output ir_dm_pkg::queue_out_type  head
);
   import ir_dm_pkg::*;

   task_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;

   assign full       = (level_ff == 2'd2);
   assign head.valid = (level_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   // pointer and level update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 2'd1;
      end else if (pop && !push) begin
         level_in = level_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/ir_dm_back.sv]
// ----------------------------------------------------------------------------
// ir_dm_back
// Serial divide, hold, history write, rank pass median and result register.
// ----------------------------------------------------------------------------
module ir_dm_back (
   input  logic                                clock,
   input  logic                                reset,
   input  ir_dm_pkg::queue_out_type            head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ir_dm_pkg::DIR_W-1:0]         rsp_direction_value,
   output logic                                rsp_direction_valid,
   output logic [ir_dm_pkg::MED_W-1:0]         rsp_median_value,
   output logic                                rsp_median_valid
);
   import ir_dm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DIV   = 5'b00010,
      S_WRITE = 5'b00100,
      S_RANK  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIVIDEND_W - 1);
   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(WINDOW_DEPTH - 1);

   state_type state_ff, state_in;

   // divider
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      div_ff, div_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CNT_W:0]        rem_sh;
   logic                  q_bit;

   // history and hold state
   logic [DIR_W-1:0]      hist_val_ff [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] hist_vld_ff, hist_vld_in;
   logic [IDX_W-1:0]      wp_ff, wp_in;
   logic [DIR_W-1:0]      held_val_ff, held_val_in;
   logic                  held_vld_ff, held_vld_in;
   logic                  prior_med_ff, prior_med_in;
   logic [DIR_W-1:0]      dir_val_ff, dir_val_in;
   logic                  dir_vld_ff, dir_vld_in;
   logic                  hist_we;

   // rank pass
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [DIR_W-1:0]      lo_ff, lo_in;
   logic [DIR_W-1:0]      hi_ff, hi_in;
   logic [RANK_W-1:0]     n_valid;
   logic [RANK_W-1:0]     half;
   logic [RANK_W-1:0]     rank;
   logic [DIR_W-1:0]      cur_val;

   // result register
   logic                  out_vld_ff, out_vld_in;
   logic [DIR_W-1:0]      out_dir_ff, out_dir_in;
   logic                  out_dvld_ff, out_dvld_in;
   logic [MED_W-1:0]      out_med_ff, out_med_in;
   logic                  out_mvld_ff, out_mvld_in;
   logic                  out_free;

   assign out_free = !out_vld_ff || !rsp_stall;

   // one restoring divide step
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      q_bit  = (rem_sh >= {1'b0, div_ff});
   end

   // rank of the entry under the scan pointer among valid entries
   assign cur_val = hist_val_ff[idx_ff];
   always_comb begin
      n_valid = '0;
      rank    = '0;
      for (int j = 0; j < WINDOW_DEPTH; j++) begin
         n_valid = n_valid + RANK_W'(hist_vld_ff[j]);
         if (hist_vld_ff[j] && ((hist_val_ff[j] < cur_val) ||
             (hist_val_ff[j] == cur_val && IDX_W'(j) < idx_ff))) begin
            rank = rank + RANK_W'(1);
         end
      end
      half = n_valid >> 1;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      hist_vld_in  = hist_vld_ff;
      hist_we      = 1'b0;
      wp_in        = wp_ff;
      held_val_in  = held_val_ff;
      held_vld_in  = held_vld_ff;
      prior_med_in = prior_med_ff;
      dir_val_in   = dir_val_ff;
      dir_vld_in   = dir_vld_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      out_vld_in   = out_vld_ff && rsp_stall;
      out_dir_in   = out_dir_ff;
      out_dvld_in  = out_dvld_ff;
      out_med_in   = out_med_ff;
      out_mvld_in  = out_mvld_ff;
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               dvd_in   = {head.item.sum, {FRACTION_BITS{1'b0}}};
               rem_in   = '0;
               div_in   = head.item.count;
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = q_bit ? CNT_W'(rem_sh - {1'b0, div_ff}) : CNT_W'(rem_sh);
            dvd_in  = {dvd_ff[DIVIDEND_W-2:0], q_bit};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            // direction, with hold of the last valid one
            dir_vld_in = (div_ff != '0);
            dir_val_in = DIR_W'(dvd_ff);
            if (div_ff == '0 && prior_med_ff) begin
               dir_vld_in = held_vld_ff;
               dir_val_in = held_val_ff;
            end
            if (!dir_vld_in) begin
               dir_val_in = '0;
            end
            if (dir_vld_in) begin
               held_vld_in = 1'b1;
               held_val_in = dir_val_in;
            end
            hist_we            = 1'b1;
            hist_vld_in[wp_ff] = dir_vld_in;
            wp_in    = (wp_ff == IDX_LAST) ? '0 : wp_ff + IDX_W'(1);
            idx_in   = '0;
            lo_in    = '0;
            hi_in    = '0;
            state_in = S_RANK;
         end
         S_RANK: begin
            if (hist_vld_ff[idx_ff]) begin
               if (rank == half) begin
                  hi_in = cur_val;
               end
               if (!n_valid[0] && (rank + RANK_W'(1)) == half) begin
                  lo_in = cur_val;
               end
            end
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_LAST) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               out_vld_in   = 1'b1;
               out_dir_in   = dir_val_ff;
               out_dvld_in  = dir_vld_ff;
               out_mvld_in  = (n_valid != '0);
               if (n_valid == '0) begin
                  out_med_in = '0;
               end else if (n_valid[0]) begin
                  out_med_in = MED_W'({hi_ff, 1'b0});
               end else begin
                  out_med_in = MED_W'({1'b0, lo_ff} + {1'b0, hi_ff});
               end
               prior_med_in = (n_valid != '0);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hist_vld_ff  <= '0;
         wp_ff        <= '0;
         held_vld_ff  <= 1'b0;
         held_val_ff  <= '0;
         prior_med_ff <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hist_vld_ff  <= hist_vld_in;
         wp_ff        <= wp_in;
         held_vld_ff  <= held_vld_in;
         held_val_ff  <= held_val_in;
         prior_med_ff <= prior_med_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      step_ff     <= step_in;
      dir_val_ff  <= dir_val_in;
      dir_vld_ff  <= dir_vld_in;
      idx_ff      <= idx_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      out_dir_ff  <= out_dir_in;
      out_dvld_ff <= out_dvld_in;
      out_med_ff  <= out_med_in;
      out_mvld_ff <= out_mvld_in;
      if (hist_we) begin
         hist_val_ff[wp_ff] <= dir_val_in;
      end
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_direction_value = out_dir_ff;
   assign rsp_direction_valid = out_dvld_ff;
   assign rsp_median_value    = out_med_ff;
   assign rsp_median_valid    = out_mvld_ff;

endmodule

[design/ir_array_direction_median.sv]
// ----------------------------------------------------------------------------
// ir_array_direction_median
// Direction of an IR receiver array as the mean active index, with hold of
// the last valid direction and a moving median over a ten-entry history.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_sensor_bits                         req_valid / req_stall
//  response  rsp_direction_value/valid, rsp_median_*  rsp_valid / rsp_stall
//
// In the back end a request goes through a load, 14 restoring divide steps
// (sum << 8 by active count), a history write, 10 rank scan steps and a
// result load; the back end takes no new request until its result is loaded.
// A two-entry queue keeps taking requests while the back end is busy, until it is full.
// A stalled response holds; the back end waits in its result step.
// Synchronous reset clears the history valid bits, hold and pointers.
// ----------------------------------------------------------------------------
module ir_array_direction_median (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ir_dm_pkg::SENSOR_W-1:0]      req_sensor_bits,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ir_dm_pkg::DIR_W-1:0]         rsp_direction_value,
   output logic                                rsp_direction_valid,
   output logic [ir_dm_pkg::MED_W-1:0]         rsp_median_value,
   output logic                                rsp_median_valid
);
   import ir_dm_pkg::*;

   task_type      class_item;
   queue_out_type head;
   logic          full;
   logic          pop;

   // classify the incoming snapshot
   ir_dm_front u_front (
      .sensor_bits (req_sensor_bits),
      .item        (class_item)
   );

   // decoupling queue
   ir_dm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !full),
      .push_item (class_item),
      .full      (full),
      .pop       (pop),
      .head      (head)
   );

   assign req_stall = full;

   // divide, history and median
   ir_dm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_direction_value (rsp_direction_value),
      .rsp_direction_valid (rsp_direction_valid),
      .rsp_median_value    (rsp_median_value),
      .rsp_median_valid    (rsp_median_valid)
   );

endmodule

[design/ir_dm_checker.sv]
// ----------------------------------------------------------------------------
// ir_dm_checker
// Port-level checks on the response channel of the direction median block.
// ----------------------------------------------------------------------------
module ir_dm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [ir_dm_pkg::DIR_W-1:0]         rsp_direction_value,
   input logic                                rsp_direction_valid,
   input logic [ir_dm_pkg::MED_W-1:0]         rsp_median_value,
   input logic                                rsp_median_valid
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_direction_value) &&
      $stable(rsp_direction_valid) && $stable(rsp_median_value) &&
      $stable(rsp_median_valid))
      else $error("response changed while stalled");

   // an invalid direction reads as zero
   a_dir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_direction_valid |-> rsp_direction_value == '0)
      else $error("invalid direction with nonzero value");

   // an empty window reads as zero
   a_med_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_median_valid |-> rsp_median_value == '0)
      else $error("invalid median with nonzero value");

   // a valid direction just entered the window, so the median is valid
   a_dir_med: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_direction_valid |-> rsp_median_valid)
      else $error("valid direction without valid median");

endmodule

bind ir_array_direction_median ir_dm_checker u_checker (.*);
